[rtl/hlpcm_pkg.sv]
`timescale 1ns / 1ps

package hlpcm_pkg;

   // Frame geometry
   localparam int MaxChannels = 8;
   localparam int ChanIdxW    = 3;
   localparam int SampleW     = 24;

   // Configuration register indexes
   localparam logic [1:0] CsrChannelCount      = 2'd0;
   localparam logic [1:0] CsrSampleWidth       = 2'd1;
   localparam logic [1:0] CsrChannelAssignment = 2'd2;

   // Channel assignment codes with a WAVE-order remap
   localparam logic [7:0] AssignFive1  = 8'd9;
   localparam logic [7:0] AssignSeven0 = 8'd10;
   localparam logic [7:0] AssignSeven1 = 8'd11;

   // Input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_end;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic signed [SampleW-1:0] sample;
      logic [ChanIdxW-1:0]       channel;
      logic                      frame_last;
   } rsp_type;

   // Active configuration as seen by the assembler
   typedef struct packed {
      logic [3:0] nch;         // saturated channel count, 0..8
      logic       wide;        // 24-bit samples
      logic [7:0] assignment;
   } cfg_type;

   // Completed frame handed from assembler to emitter
   typedef struct packed {
      logic                                   load;
      logic [ChanIdxW-1:0]                    last_idx;
      logic [MaxChannels-1:0][SampleW-1:0]    samples;
   } frame_type;

   // Disc channel index to WAVE slot
   function automatic logic [ChanIdxW-1:0] remap_slot(
      input logic [7:0]          assignment,
      input logic [3:0]          nch,
      input logic [ChanIdxW-1:0] c
   );
      logic [ChanIdxW-1:0] slot;
      slot = c;
      if (assignment == AssignFive1 && nch == 4'd6) begin
         unique case (c)
            3'd3:    slot = 3'd4;
            3'd4:    slot = 3'd5;
            3'd5:    slot = 3'd3;
            default: slot = c;
         endcase
      end else if (assignment == AssignSeven0 && nch == 4'd7) begin
         unique case (c)
            3'd3:    slot = 3'd5;
            3'd4:    slot = 3'd3;
            3'd5:    slot = 3'd4;
            default: slot = c;
         endcase
      end else if (assignment == AssignSeven1 && nch == 4'd8) begin
         unique case (c)
            3'd3:    slot = 3'd6;
            3'd6:    slot = 3'd7;
            3'd7:    slot = 3'd3;
            default: slot = c;
         endcase
      end
      return slot;
   endfunction

endpackage

[rtl/hlpcm_asm.sv]
`timescale 1ns / 1ps

module hlpcm_asm import hlpcm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      cfg_wr,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  logic      emit_free,
   output frame_type frame
);

   logic [15:0]                          accum_ff, accum_in;
   logic [1:0]                           byte_ff, byte_in;
   logic [ChanIdxW-1:0]                  chan_ff, chan_in;
   logic [MaxChannels-1:0][SampleW-1:0]  slots_ff, slots_in;

   logic                 accept;
   logic                 byte_last;
   logic                 frame_done;
   logic                 active;
   logic [ChanIdxW-1:0]  last_chan;
   logic [ChanIdxW-1:0]  slot;
   logic [SampleW-1:0]   value;
   logic                 slot_wr;

   assign active     = (cfg.nch != 4'd0);
   assign last_chan  = ChanIdxW'(cfg.nch - 4'd1);
   assign byte_last  = cfg.wide ? (byte_ff == 2'd2) : (byte_ff == 2'd1);
   assign frame_done = active && byte_last && (chan_ff == last_chan);

   // stall only when a frame would finish while the emitter is still busy
   assign req_ready = !frame_done || emit_free;
   assign accept    = req_valid && req_ready;

   // big-endian sample assembly; 16-bit samples land in the upper bits
   assign value   = cfg.wide ? {accum_ff, req_data.data_byte}
                             : {accum_ff[7:0], req_data.data_byte, 8'h00};
   assign slot    = remap_slot(cfg.assignment, cfg.nch, chan_ff);
   assign slot_wr = accept && active && byte_last;

   // slot store with the current sample merged for the emitter copy
   always_comb begin
      slots_in = slots_ff;
      if (slot_wr) begin
         slots_in[slot] = value;
      end
   end

   assign frame.load     = accept && frame_done;
   assign frame.last_idx = last_chan;
   assign frame.samples  = slots_in;

   // position and accumulator update
   always_comb begin
      accum_in = accum_ff;
      byte_in  = byte_ff;
      chan_in  = chan_ff;
      if (cfg_wr) begin
         accum_in = '0;
         byte_in  = '0;
         chan_in  = '0;
      end else if (accept) begin
         if (!active || req_data.packet_end) begin
            accum_in = '0;
            byte_in  = '0;
            chan_in  = '0;
         end else begin
            accum_in = {accum_ff[7:0], req_data.data_byte};
            if (byte_last) begin
               byte_in = '0;
               if (frame_done) begin
                  accum_in = '0;
                  chan_in  = '0;
               end else begin
                  chan_in = chan_ff + 3'd1;
               end
            end else begin
               byte_in = byte_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         byte_ff  <= '0;
         chan_ff  <= '0;
      end else begin
         accum_ff <= accum_in;
         byte_ff  <= byte_in;
         chan_ff  <= chan_in;
      end
   end

   // frame slots: payload only, no reset
   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

endmodule

[rtl/hlpcm_emit.sv]
`timescale 1ns / 1ps

module hlpcm_emit import hlpcm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  frame_type frame,
   output logic      emit_free,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic                                 busy_ff, busy_in;
   logic [ChanIdxW-1:0]                  idx_ff, idx_in;
   logic [ChanIdxW-1:0]                  last_ff, last_in;
   logic [MaxChannels-1:0][SampleW-1:0]  buf_ff, buf_in;

   logic take;
   logic at_last;

   assign take      = busy_ff && rsp_ready;
   assign at_last   = (idx_ff == last_ff);
   assign emit_free = !busy_ff || (rsp_ready && at_last);

   // result transaction straight from the frame buffer
   assign rsp_valid           = busy_ff;
   assign rsp_data.sample     = buf_ff[idx_ff];
   assign rsp_data.channel    = idx_ff;
   assign rsp_data.frame_last = at_last;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      buf_in  = buf_ff;
      if (frame.load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         last_in = frame.last_idx;
         buf_in  = frame.samples;
      end else if (take) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         last_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

[rtl/hdmv_lpcm_to_interleaved_pcm_top.sv]
`timescale 1ns / 1ps
// The byte that completes a frame registers the frame into the emitter buffer as
// it is accepted; samples then leave one per cycle while the result side is ready.
// Throughput: one byte per cycle; a frame of n channels yields n samples
// from a double buffer, so input stalls only when the result side holds off.
// Reset: synchronous, active high; registers return to 2 channels, 16-bit.

module hdmv_lpcm_to_interleaved_pcm_top import hlpcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wen,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   logic [3:0] count_ff, count_in;
   logic       wide_ff, wide_in;
   logic [7:0] assign_ff, assign_in;

   cfg_type   cfg;
   logic      cfg_wr;
   logic      emit_free;
   frame_type frame;

   // configuration registers; any valid write also drops the partial frame
   always_comb begin
      count_in  = count_ff;
      wide_in   = wide_ff;
      assign_in = assign_ff;
      cfg_wr    = 1'b0;
      if (csr_wen) begin
         unique case (csr_index)
            CsrChannelCount: begin
               count_in = csr_wdata[3:0];
               cfg_wr   = 1'b1;
            end
            CsrSampleWidth: begin
               wide_in = csr_wdata[0];
               cfg_wr  = 1'b1;
            end
            CsrChannelAssignment: begin
               assign_in = csr_wdata;
               cfg_wr    = 1'b1;
            end
            default: begin
               cfg_wr = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 4'd2;
         wide_ff   <= 1'b0;
         assign_ff <= 8'd0;
      end else begin
         count_ff  <= count_in;
         wide_ff   <= wide_in;
         assign_ff <= assign_in;
      end
   end

   // saturate channel count to the frame size
   assign cfg.nch        = (count_ff > 4'(MaxChannels)) ? 4'(MaxChannels) : count_ff;
   assign cfg.wide       = wide_ff;
   assign cfg.assignment = assign_ff;

   hlpcm_asm u_asm (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_wr    (cfg_wr),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .emit_free (emit_free),
      .frame     (frame)
   );

   hlpcm_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .frame     (frame),
      .emit_free (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[sim/hlpcm_checker.sv]
`timescale 1ns / 1ps

module hlpcm_checker import hlpcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_wen,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         fail_count,
   output int         pending_count
);

   // Disc channel index to WAVE slot, per remapped layout
   int five1_order  [6] = '{0, 1, 2, 4, 5, 3};
   int seven0_order [7] = '{0, 1, 2, 5, 3, 4, 6};
   int seven1_order [8] = '{0, 1, 2, 6, 4, 5, 7, 3};

   // Shadow of the configuration registers
   logic [3:0]  count_reg;
   logic        width_reg;
   logic [7:0]  assign_reg;

   // Shadow of the frame assembly state
   logic [23:0] frame_buf [8];
   logic [23:0] byte_shift;
   int          byte_pos;

   // Samples predicted but not yet seen on the result channel
   rsp_type     sample_q [$];
   int          errors = 0;

   assign fail_count = errors;

   function automatic int wave_slot(int c, int nch);
      if (assign_reg == AssignFive1 && nch == 6) return five1_order[c];
      if (assign_reg == AssignSeven0 && nch == 7) return seven0_order[c];
      if (assign_reg == AssignSeven1 && nch == 8) return seven1_order[c];
      return c;
   endfunction

   function automatic void drop_partial();
      byte_shift = '0;
      byte_pos   = 0;
   endfunction

   // Advance the assembler by one byte; queue a frame once it is complete
   function automatic void absorb_byte(req_type t);
      int          nch;
      int          bps;
      logic [23:0] v;
      rsp_type     r;
      nch = (count_reg > 4'd8) ? 8 : int'(count_reg);
      bps = width_reg ? 3 : 2;
      if (nch == 0) begin
         drop_partial();
         return;
      end
      byte_shift = {byte_shift[15:0], t.data_byte};
      if (byte_pos % bps == bps - 1) begin
         v = (bps == 2) ? {byte_shift[15:0], 8'h00} : byte_shift;
         frame_buf[wave_slot(byte_pos / bps, nch)] = v;
      end
      byte_pos++;
      if (byte_pos >= nch * bps) begin
         for (int k = 0; k < nch; k++) begin
            r.sample     = frame_buf[k];
            r.channel    = k[2:0];
            r.frame_last = (k == nch - 1);
            sample_q.push_back(r);
         end
         drop_partial();
      end
      if (t.packet_end) drop_partial();
   endfunction

   function automatic void report_mismatch(string why, rsp_type want, rsp_type got);
      errors++;
      if (errors <= 10)
         $display("%0t mismatch (%s): expected sample %0d ch %0d last %0b, got sample %0d ch %0d last %0b",
                  $realtime, why, want.sample, want.channel, want.frame_last,
                  got.sample, got.channel, got.frame_last);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         count_reg  = 4'd2;
         width_reg  = 1'b0;
         assign_reg = 8'd0;
         drop_partial();
         sample_q.delete();
      end else begin
         // Register writes; an unmapped index leaves the frame alone
         if (csr_wen) begin
            case (csr_index)
               CsrChannelCount: begin
                  count_reg = csr_wdata[3:0];
                  drop_partial();
               end
               CsrSampleWidth: begin
                  width_reg = csr_wdata[0];
                  drop_partial();
               end
               CsrChannelAssignment: begin
                  assign_reg = csr_wdata;
                  drop_partial();
               end
               default: ;
            endcase
         end

         if (req_valid && req_ready) absorb_byte(req_data);

         // Compare each result transaction with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (sample_q.size() == 0) begin
               report_mismatch("no sample pending", '0, rsp_data);
            end else begin
               if (rsp_data.sample !== sample_q[0].sample ||
                   rsp_data.channel !== sample_q[0].channel ||
                   rsp_data.frame_last !== sample_q[0].frame_last)
                  report_mismatch("field", sample_q[0], rsp_data);
               void'(sample_q.pop_front());
            end
         end
      end
      pending_count <= sample_q.size();
   end

endmodule

[sim/hdmv_lpcm_to_interleaved_pcm_top_tb.sv]
`timescale 1ns / 1ps

module hdmv_lpcm_to_interleaved_pcm_top_tb;
   import hlpcm_pkg::*;

   localparam int         IdleLimit   = 4000;
   localparam int         RandomItems = 220;
   localparam logic [1:0] CsrUnmapped = 2'd3;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wen   = 1'b0;
   logic [1:0] csr_index = CsrChannelCount;
   logic [7:0] csr_wdata = 8'd0;

   int fail_count;
   int pending_count;
   int burst_left  = 0;
   int gap_max     = 0;
   int stall_mode  = 0;
   int stall_hold  = 0;
   int idle_cycles = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   hdmv_lpcm_to_interleaved_pcm_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hlpcm_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Result side back-pressure, style picked per phase
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold--;
      end else begin
         case (stall_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready  <= 1'($urandom_range(0, 1));
               stall_hold = $urandom_range(0, 3);
            end
            2: begin
               // mostly stalled, ready for single cycles
               rsp_ready  <= ~rsp_ready;
               stall_hold = rsp_ready ? $urandom_range(2, 8) : 0;
            end
            default: begin
               rsp_ready  <= ~rsp_ready;
               stall_hold = $urandom_range(0, 20);
            end
         endcase
      end
   end

   // Watchdog: too long with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // One byte transaction; bursts of random length, random gaps between
   task automatic send_byte(input logic [7:0] b, input logic pe);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_data.data_byte  <= b;
      req_data.packet_end <= pe;
      do @(posedge clock); while (!req_ready);
   endtask

   // n random bytes, packet end flag on the last one
   task automatic send_run(input int n, input logic pe_last);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom_range(0, 255)), (i == n - 1) ? pe_last : 1'b0);
   endtask

   // Go idle and drain: every predicted sample out, then some slack
   task automatic phase_end();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] d);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] cc, input logic [7:0] sw,
                               input logic [7:0] asg);
      csr_write(CsrChannelCount, cc);
      csr_write(CsrSampleWidth, sw);
      csr_write(CsrChannelAssignment, asg);
      csr_wen <= 1'b0;
   endtask

   initial begin
      int          nch;
      int          bps;
      int          fb;
      int          frames;
      int          cut;
      int          sent_random;
      int          sel;
      logic [3:0]  cc;
      logic        sw;
      logic [7:0]  asg;

      sent_random = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: 2 channels, 16-bit; zero, -1, min and max
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b0);
      phase_end();

      // Unmapped index, then mono 24-bit with upper data bits set
      csr_write(CsrUnmapped, 8'hFF);
      program_regs(8'hF1, 8'hFF, 8'hFF);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // packet end inside a sample drops it
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      // packet end on the frame's last byte still emits the frame
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // partial sample discarded by the next register write
      send_byte(8'hAB, 1'b0);
      phase_end();

      // Zero channels: bytes are swallowed
      program_regs(8'h00, 8'h00, 8'h00);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
      send_byte(8'h01, 1'b0);
      phase_end();

      // Random phases, each with its own register setting
      while (sent_random < RandomItems) begin
         sel = $urandom_range(0, 7);
         sw  = 1'($urandom_range(0, 1));
         asg = 8'($urandom_range(0, 255));
         case (sel)
            0: begin
               cc  = $urandom_range(0, 1) ? 4'd8 : 4'd15;
               sw  = 1'b1;
               asg = AssignSeven1;
            end
            1: begin
               cc  = 4'd6;
               asg = AssignFive1;
            end
            2: begin
               cc  = 4'd7;
               asg = AssignSeven0;
            end
            3: begin
               cc = 4'd1;
            end
            default: begin
               cc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, 8));
               if ($urandom_range(0, 2) == 0) asg = 8'($urandom_range(9, 11));
            end
         endcase

         if ($urandom_range(0, 5) == 0) csr_write(CsrUnmapped, 8'($urandom_range(0, 255)));
         program_regs({4'($urandom_range(0, 15)), cc}, {7'($urandom_range(0, 127)), sw}, asg);

         stall_mode = $urandom_range(0, 3);
         case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 3;
            default: gap_max = 10;
         endcase

         nch = (cc > 4'd8) ? 8 : int'(cc);
         bps = sw ? 3 : 2;
         fb  = nch * bps;
         if (nch == 0) begin
            send_run(4, 1'($urandom_range(0, 1)));
         end else begin
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++) begin
               if ($urandom_range(0, 7) == 0) begin
                  // broken frame: packet ends early
                  cut = $urandom_range(1, fb - 1);
                  send_run(cut, 1'b1);
                  sent_random += cut;
               end else begin
                  send_run(fb, ($urandom_range(0, 3) == 0));
                  sent_random += fb;
               end
            end
            // stray bytes left for the next register write to discard
            if ($urandom_range(0, 3) == 0) begin
               cut = $urandom_range(1, fb - 1);
               send_run(cut, 1'b0);
               sent_random += cut;
            end
         end
         phase_end();
      end

      stall_mode = 0;
      repeat (16) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
